>>> rtl/fgemm_pkg.sv
// Shared constants, payload types and register codes for the fp16-weight GEMM accumulate block.
// Depends on nothing; imported by the front end, queue, back end and top level.
package fgemm_pkg;

    localparam int ROWS           = 6;
    localparam int LANES          = 16;
    localparam int MAX_COL_BLOCKS = 16;
    localparam int COL_GROUP      = 2;
    localparam int COLS           = MAX_COL_BLOCKS * LANES * COL_GROUP;
    localparam int ENTRIES        = ROWS * COLS;
    localparam int ADDR_W         = $clog2(ENTRIES);
    localparam int FMA_LAT        = 9;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = CFG_IDX_W'(1);

    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [8:0]  col_index;
        logic [11:0] depth_index;
        logic [31:0] a_bits;
        logic [15:0] b_half;
        logic [31:0] c_prior;
    } t_in;

    typedef struct packed {
        logic [3:0]  out_row;
        logic [8:0]  out_col;
        logic [31:0] c_bits;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [3:0]        row;
        logic [8:0]        col;
        logic              first;
        logic              last;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
    } t_term;

endpackage

>>> rtl/fgemm_fma.sv
// Nine-stage pipelined binary32 fused multiply-add with a single nearest-even rounding.
// Self-contained; used twice by fgemm_back.
module fgemm_fma (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    output logic [31:0] o_r
);

    typedef struct packed {
        logic        spec;
        logic [31:0] sv;
    } t_fspec;

    localparam logic [30:0] INF_MAG = 31'h7F80_0000;
    localparam logic [31:0] QNAN    = 32'h7FC0_0000;

    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic logic [23:0] mant(input logic [31:0] v);
        return {(v[30:23] != 8'd0), v[22:0]};
    endfunction

    function automatic logic signed [11:0] expo(input logic [31:0] v);
        logic signed [11:0] e;
        if (v[30:23] == 8'd0) e = -12'sd149;
        else e = $signed({4'b0, v[30:23]}) - 12'sd150;
        return e;
    endfunction

    logic              w_sp, w_sz;
    logic [30:0]       w_ax, w_ay, w_az;
    logic [23:0]       w_mx, w_my;
    logic [47:0]       w_mp;
    t_fspec            w_f1;

    t_fspec            r1_f, r2_f, r3_f, r4_f, r5_f, r6_f, r7_f, r8_f;
    logic [47:0]       r1_mp, r2_mp;
    logic [23:0]       r1_mz, r2_mz;
    logic signed [11:0] r1_ep, r1_ez, r2_ep, r2_ez, r3_ep, r3_ez;
    logic              r1_sp, r1_sz, r1_zz, r2_sp, r2_sz, r2_zz, r3_sp, r3_sz, r3_zz;
    logic [6:0]        r2_dp, r2_dz;
    logic [63:0]       r3_np, r3_nz;
    logic [63:0]       r4_big, r4_small, r5_big, r5_sm, r6_sum, r7_sum;
    logic signed [11:0] r4_eb, r5_eb, r6_eb, r7_eb, r7_sh, r8_lsb;
    logic              r4_sb, r4_sub, r5_sb, r5_sub, r6_sb, r7_sb, r8_sb;
    logic [5:0]        r4_d;
    logic [24:0]       r8_q;
    logic              r8_rnd, r8_stk;
    logic [31:0]       r9_r;

    always_comb begin
        w_sp = i_x[31] ^ i_y[31];
        w_sz = i_z[31];
        w_ax = i_x[30:0];
        w_ay = i_y[30:0];
        w_az = i_z[30:0];
        w_mx = mant(i_x);
        w_my = mant(i_y);
        w_f1.spec = 1'b1;
        w_f1.sv   = QNAN;
        if (w_ax > INF_MAG || w_ay > INF_MAG || w_az > INF_MAG) begin
            w_f1.sv = QNAN;
        end else if (w_ax == INF_MAG || w_ay == INF_MAG) begin
            if (w_ax == 31'd0 || w_ay == 31'd0) w_f1.sv = QNAN;
            else if (w_az == INF_MAG && w_sz != w_sp) w_f1.sv = QNAN;
            else w_f1.sv = {w_sp, INF_MAG};
        end else if (w_az == INF_MAG) begin
            w_f1.sv = i_z;
        end else if (w_ax == 31'd0 || w_ay == 31'd0) begin
            w_f1.sv = (w_az == 31'd0) ? {w_sp & w_sz, 31'd0} : i_z;
        end else begin
            w_f1.spec = 1'b0;
        end
    end

    assign w_mp = w_mx * w_my;

    logic signed [11:0] w4_diff;
    logic               w4_pbig;
    logic [127:0]       w5_t;
    logic [5:0]         w7_p;
    logic signed [11:0] w7_sh, w7_lim;
    logic [128:0]       w8_tr;
    logic [6:0]         w8_shc;
    logic [4:0]         w8_nsh;
    logic [24:0]        w9_qr;
    logic [23:0]        w9_qn;
    logic signed [11:0] w9_lsb, w9_be;
    logic [31:0]        w9_r;

    always_comb begin
        w4_pbig = (r3_ep > r3_ez) || (r3_ep == r3_ez && r3_np >= r3_nz);
        w4_diff = w4_pbig ? (r3_ep - r3_ez) : (r3_ez - r3_ep);
        w5_t    = {r4_small, 64'd0} >> r4_d;
        w7_p    = top_bit(r6_sum);
        w7_sh   = $signed({6'd0, w7_p}) - 12'sd23;
        w7_lim  = -12'sd149 - r6_eb;
        w8_shc  = (r7_sh > 12'sd65) ? 7'd65 : r7_sh[6:0];
        w8_nsh  = 5'(-r7_sh);
        w8_tr   = {r7_sum, 65'd0} >> w8_shc;
        w9_qr   = r8_q + 25'(r8_rnd && (r8_stk || r8_q[0]));
        w9_qn   = w9_qr[24] ? w9_qr[24:1] : w9_qr[23:0];
        w9_lsb  = r8_lsb + (w9_qr[24] ? 12'sd1 : 12'sd0);
        w9_be   = w9_lsb + 12'sd150;
        if (r8_f.spec) w9_r = r8_f.sv;
        else if (!w9_qn[23]) w9_r = {r8_sb, 8'd0, w9_qn[22:0]};
        else if (w9_be >= 12'sd255) w9_r = {r8_sb, INF_MAG};
        else w9_r = {r8_sb, w9_be[7:0], w9_qn[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f  <= w_f1;
            r1_mp <= w_mp;
            r1_ep <= expo(i_x) + expo(i_y);
            r1_mz <= mant(i_z);
            r1_ez <= expo(i_z);
            r1_sp <= w_sp;
            r1_sz <= w_sz;
            r1_zz <= (w_az == 31'd0);

            r2_f  <= r1_f;
            r2_mp <= r1_mp;
            r2_mz <= r1_mz;
            r2_ep <= r1_ep;
            r2_ez <= r1_ez;
            r2_sp <= r1_sp;
            r2_sz <= r1_sz;
            r2_zz <= r1_zz;
            r2_dp <= 7'd62 - {1'b0, top_bit({16'd0, r1_mp})};
            r2_dz <= 7'd62 - {1'b0, top_bit({40'd0, r1_mz})};

            r3_f  <= r2_f;
            r3_np <= {16'd0, r2_mp} << r2_dp;
            r3_nz <= {40'd0, r2_mz} << r2_dz;
            r3_ep <= r2_ep - $signed({5'd0, r2_dp});
            r3_ez <= r2_ez - $signed({5'd0, r2_dz});
            r3_sp <= r2_sp;
            r3_sz <= r2_sz;
            r3_zz <= r2_zz;

            r4_f <= r3_f;
            if (r3_zz) begin
                r4_big   <= r3_np;
                r4_small <= 64'd0;
                r4_eb    <= r3_ep;
                r4_sb    <= r3_sp;
                r4_d     <= 6'd0;
                r4_sub   <= 1'b0;
            end else begin
                r4_big   <= w4_pbig ? r3_np : r3_nz;
                r4_small <= w4_pbig ? r3_nz : r3_np;
                r4_eb    <= w4_pbig ? r3_ep : r3_ez;
                r4_sb    <= w4_pbig ? r3_sp : r3_sz;
                r4_d     <= (w4_diff > 12'sd63) ? 6'd63 : w4_diff[5:0];
                r4_sub   <= r3_sp ^ r3_sz;
            end

            r5_f   <= r4_f;
            r5_big <= r4_big;
            r5_sm  <= w5_t[127:64] | {63'd0, |w5_t[63:0]};
            r5_eb  <= r4_eb;
            r5_sb  <= r4_sb;
            r5_sub <= r4_sub;

            r6_f   <= r5_f;
            r6_sum <= r5_sub ? (r5_big - r5_sm) : (r5_big + r5_sm);
            r6_eb  <= r5_eb;
            r6_sb  <= r5_sb;

            if (!r6_f.spec && r6_sum == 64'd0) r7_f <= '{spec: 1'b1, sv: 32'd0};
            else r7_f <= r6_f;
            r7_sum <= r6_sum;
            r7_eb  <= r6_eb;
            r7_sb  <= r6_sb;
            r7_sh  <= (w7_lim > w7_sh) ? w7_lim : w7_sh;

            r8_f   <= r7_f;
            r8_sb  <= r7_sb;
            r8_lsb <= r7_eb + r7_sh;
            if (r7_sh <= 12'sd0) begin
                r8_q   <= 25'(r7_sum[23:0]) << w8_nsh;
                r8_rnd <= 1'b0;
                r8_stk <= 1'b0;
            end else begin
                r8_q   <= w8_tr[89:65];
                r8_rnd <= w8_tr[64];
                r8_stk <= |w8_tr[63:0];
            end

            r9_r <= w9_r;
        end
    end

    assign o_r = r9_r;

endmodule

>>> rtl/fgemm_front.sv
// Front end: takes input transfers, drops out-of-range terms, widens B and tags each term.
// Depends on fgemm_pkg; feeds fgemm_queue.
module fgemm_front (
    input  logic            i_in_valid,
    input  fgemm_pkg::t_in  i_in_data,
    input  logic            i_q_full,
    input  logic [12:0]     i_depth_count,
    output logic            o_in_stall,
    output logic            o_push,
    output fgemm_pkg::t_term o_term
);
    import fgemm_pkg::*;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [3:0]  p;
        logic [31:0] r;
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h[i]) p = 4'(i);
        end
        if (h[14:10] == 5'd31) begin
            r = {h[15], 8'hFF, h[9:0], 13'd0};
        end else if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) r = {h[15], 31'd0};
            else r = {h[15], 8'(p) + 8'd103, 23'({13'd0, h[9:0]} << (5'd23 - 5'(p)))};
        end else begin
            r = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
        end
        return r;
    endfunction

    logic w_keep;

    always_comb begin
        w_keep = (32'(i_in_data.row_index) < ROWS) && (32'(i_in_data.col_index) < COLS) &&
                 ({1'b0, i_in_data.depth_index} < i_depth_count);
        o_term.addr  = ADDR_W'(ADDR_W'(i_in_data.row_index) * ADDR_W'(COLS)) +
                       ADDR_W'(i_in_data.col_index);
        o_term.row   = i_in_data.row_index;
        o_term.col   = i_in_data.col_index;
        o_term.first = (i_in_data.depth_index == 12'd0);
        o_term.last  = ({1'b0, i_in_data.depth_index} + 13'd1 == i_depth_count);
        o_term.a     = i_in_data.a_bits;
        o_term.b     = half_to_single(i_in_data.b_half);
        o_term.c     = i_in_data.c_prior;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && w_keep;

endmodule

>>> rtl/fgemm_queue.sv
// Short FIFO of tagged terms between the front end and the arithmetic back end.
// Depends on fgemm_pkg.
module fgemm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fgemm_pkg::t_term i_term,
    input  logic             i_pop,
    output logic             o_valid,
    output fgemm_pkg::t_term o_head,
    output logic             o_full
);
    import fgemm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_term            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop) r_rd <= r_rd + PTR_W'(1);
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_term;
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

endmodule

>>> rtl/fgemm_back.sv
// Back end: accumulator memory, hazard check, beta scaling and accumulate FMA pipelines.
// Depends on fgemm_pkg and fgemm_fma.
module fgemm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  fgemm_pkg::t_term i_head,
    output logic             o_pop,
    input  logic [31:0]      i_beta,
    output logic             o_out_valid,
    output fgemm_pkg::t_out  o_out_data,
    input  logic             i_out_stall
);
    import fgemm_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [3:0]        row;
        logic [8:0]        col;
        logic              first;
        logic              last;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] acc;
    } t_side;

    logic [31:0]        r_mem [ENTRIES];
    logic [31:0]        r_acc;
    t_term              r_s0;
    logic               r_v0;
    logic [FMA_LAT-1:0] r_v1, r_v2;
    t_side              r_d1 [FMA_LAT];
    t_tag               r_d2 [FMA_LAT];
    logic               r_out_valid;
    t_out               r_out;

    logic        w_en, w_hazard;
    logic [31:0] w_scaled, w_z2, w_sum;

    assign w_en = !r_out_valid || !i_out_stall;

    always_comb begin
        w_hazard = 1'b0;
        if (!i_head.first) begin
            if (r_v0 && r_s0.addr == i_head.addr) w_hazard = 1'b1;
            for (int i = 0; i < FMA_LAT; i++) begin
                if (r_v1[i] && r_d1[i].tag.addr == i_head.addr) w_hazard = 1'b1;
                if (r_v2[i] && r_d2[i].addr == i_head.addr) w_hazard = 1'b1;
            end
        end
    end

    assign o_pop = w_en && i_head_valid && !w_hazard;

    fgemm_fma u_scale (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_beta),
        .i_y   (r_s0.c),
        .i_z   (NEG_ZERO),
        .o_r   (w_scaled)
    );

    assign w_z2 = r_d1[FMA_LAT-1].tag.first ?
                  ((|i_beta[30:0]) ? w_scaled : NEG_ZERO) : r_d1[FMA_LAT-1].acc;

    fgemm_fma u_accum (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_d1[FMA_LAT-1].a),
        .i_y   (r_d1[FMA_LAT-1].b),
        .i_z   (w_z2),
        .o_r   (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= '0;
            r_v2        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v0        <= o_pop;
            r_v1        <= {r_v1[FMA_LAT-2:0], r_v0};
            r_v2        <= {r_v2[FMA_LAT-2:0], r_v1[FMA_LAT-1]};
            r_out_valid <= r_v2[FMA_LAT-1] && r_d2[FMA_LAT-1].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (o_pop) r_s0 <= i_head;
            r_d1[0] <= '{tag: '{addr: r_s0.addr, row: r_s0.row, col: r_s0.col,
                                first: r_s0.first, last: r_s0.last},
                         a: r_s0.a, b: r_s0.b, acc: r_acc};
            for (int i = 1; i < FMA_LAT; i++) begin
                r_d1[i] <= r_d1[i-1];
                r_d2[i] <= r_d2[i-1];
            end
            r_d2[0] <= r_d1[FMA_LAT-1].tag;
            r_out   <= '{out_row: r_d2[FMA_LAT-1].row, out_col: r_d2[FMA_LAT-1].col,
                         c_bits: w_sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (o_pop) r_acc <= r_mem[i_head.addr];
            if (r_v2[FMA_LAT-1]) r_mem[r_d2[FMA_LAT-1].addr] <= w_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && !r_s0.first && r_v2[FMA_LAT-1] |-> r_s0.addr != r_d2[FMA_LAT-1].addr)
        else $error("accumulator read overlaps a pending write");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v0) && $stable(r_v1) && $stable(r_v2))
        else $error("pipeline moved while stalled");
    a_emit_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v2[FMA_LAT-1] && !r_d2[FMA_LAT-1].last |=> !r_out_valid)
        else $error("result emitted for a term that is not the last depth step");
`endif

endmodule

>>> rtl/fp16_weight_gemm_accumulate.sv
// Top level: configuration registers, front end, term queue and arithmetic back end.
// A result is offered after its last term passes the issue register, both FMA pipelines and r_out.
// Throughput: one term per cycle while the output is not stalled; a term that revisits an entry
// still in the 19-stage accumulate pipeline waits until that entry's write has landed.
// Reset: synchronous, active low; clears control state and sets beta to zero and depth to one.
// The accumulator memory is not cleared; every entry is set by its depth-zero term.
module fp16_weight_gemm_accumulate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fgemm_pkg::t_in                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fgemm_pkg::t_out                o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fgemm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import fgemm_pkg::*;

    logic [31:0] r_beta;
    logic [12:0] r_depth_count;
    logic        w_q_full, w_push, w_pop, w_head_valid;
    t_term       w_term, w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta        <= 32'd0;
            r_depth_count <= 13'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BETA: begin
                    r_beta <= i_cfg_data;
                end
                CFG_DEPTH: begin
                    r_depth_count <= i_cfg_data[12:0];
                end
                default: begin
                end
            endcase
        end
    end

    fgemm_front u_front (
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_q_full      (w_q_full),
        .i_depth_count (r_depth_count),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_term        (w_term)
    );

    fgemm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_term  (w_term),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head),
        .o_full  (w_q_full)
    );

    fgemm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_beta       (r_beta),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
